// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the ready queue RTL. Each macro expects
// clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge out of reset.
`define POQ_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define POQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/poq_pkg.sv =====
// ----------------------------------------------------------------------------
// poq_pkg
// Shared types, codes and helper functions of the policy ordered ready queue.
// ----------------------------------------------------------------------------
package poq_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [9:0]  TICK_MS      = 10'd600;
	localparam logic [21:0] DEADLINE_MAX = 22'h3FFFFF;

	localparam logic [2:0] POLICY_RST   = 3'd0;
	localparam logic [9:0] CANAL_LEN_RST = 10'd10;
	localparam logic [3:0] QLIMIT_RST   = 4'd4;
	localparam logic [15:0] NEXT_ID_RST = 16'd1;

	typedef enum logic [2:0] {
		POL_FCFS = 3'd0,
		POL_RR   = 3'd1,
		POL_PRIO = 3'd2,
		POL_SJF  = 3'd3,
		POL_STRN = 3'd4,
		POL_EDF  = 3'd5
	} poq_policy_t;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2
	} poq_op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} poq_status_t;

	typedef enum logic [1:0] {
		REG_POLICY    = 2'd0,
		REG_CANAL_LEN = 2'd1,
		REG_QLIMIT    = 2'd2
	} poq_reg_t;

	typedef enum logic [1:0] {
		TYPE_NORMAL = 2'd0,
		TYPE_FISHER = 2'd1,
		TYPE_PATROL = 2'd2
	} poq_ship_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_BUSY = 1'b1
	} poq_fsm_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        dir;
		logic [1:0]  ship_type;
		logic [9:0]  priority_req;
		logic [19:0] burst_req;
		logic [21:0] deadline_req;
		logic [15:0] target_id;
	} poq_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] entry_id_out;
		logic [9:0]  priority_out;
		logic [19:0] burst_out;
		logic [21:0] deadline_out;
		logic [2:0]  occupancy;
	} poq_rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [9:0]  prio;
		logic [19:0] burst;
		logic [21:0] dl;
	} poq_entry_t;

	// Command shared by every cell of a row
	typedef struct packed {
		logic mode_ins;  // insert; otherwise remove
		logic mode_pop;  // remove the head instead of an id match
		logic wr;        // commit the shift this cycle
	} poq_cell_ctl_t;

	function automatic logic [9:0] type_priority(input logic [1:0] t);
		case (t)
			TYPE_FISHER: type_priority = 10'd5;
			TYPE_PATROL: type_priority = 10'd10;
			default:     type_priority = 10'd1;
		endcase
	endfunction

	// ceil(len / speed) for speeds 1, 2 and 3; divide by 3 via 683/2048
	function automatic logic [9:0] ceil_div_speed(input logic [9:0] len,
		input logic [1:0] t);
		logic [10:0] y;
		logic [21:0] p;
		y = 11'(len) + 11'd2;
		p = 22'(y) * 22'd683;
		case (t)
			TYPE_FISHER: ceil_div_speed = 10'((11'(len) + 11'd1) >> 1);
			TYPE_PATROL: ceil_div_speed = p[20:11];
			default:     ceil_div_speed = len;
		endcase
	endfunction

endpackage

// ===== rtl/poq_cell.sv =====
// ----------------------------------------------------------------------------
// poq_cell
// One queue slot: holds an entry, compares it with the request and shifts
// toward either neighbor.
// ----------------------------------------------------------------------------
module poq_cell
	import poq_pkg::*;
(
	input  logic          clk,
	input  poq_cell_ctl_t ctl,
	input  logic [2:0]    policy,
	input  logic          live,
	input  logic          prev_found,
	input  poq_entry_t    new_entry,
	input  poq_entry_t    left_entry,
	input  poq_entry_t    right_entry,
	input  logic [15:0]   target_id,
	output poq_entry_t    entry,
	output logic          here,
	output logic          found_out
);

	poq_entry_t entry_q;
	logic       beats;
	logic       hit;

	always_comb begin
		case (policy)
			POL_PRIO:          beats = new_entry.prio > entry_q.prio;
			POL_SJF, POL_STRN: beats = new_entry.burst < entry_q.burst;
			POL_EDF:           beats = new_entry.dl < entry_q.dl;
			default:           beats = 1'b0;
		endcase
	end

	// insert lands at the first slot it beats or the first free slot
	assign hit = ctl.mode_ins ? (!live || beats)
		: (live && (ctl.mode_pop || entry_q.id == target_id));
	assign here      = hit && !prev_found;
	assign found_out = prev_found || hit;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (ctl.mode_ins) begin
				if (here)
					entry_q <= new_entry;
				else if (prev_found)
					entry_q <= left_entry;
			end else if (here || prev_found) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

// ===== rtl/poq_row.sv =====
// ----------------------------------------------------------------------------
// poq_row
// One ready queue as a chain of cells, head at cell 0.
// ----------------------------------------------------------------------------
module poq_row
	import poq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  poq_cell_ctl_t ctl,
	input  logic [2:0]    policy,
	input  logic [CW-1:0] cnt,
	input  poq_entry_t    new_entry,
	input  logic [15:0]   target_id,
	output logic          found,
	output poq_entry_t    sel_entry
);

	poq_entry_t cell_entry [QUEUE_DEPTH];
	logic       cell_here  [QUEUE_DEPTH];
	logic       chain      [QUEUE_DEPTH+1];

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		poq_entry_t left_e;
		poq_entry_t right_e;
		logic       live;

		assign live    = CW'(i) < cnt;
		assign left_e  = (i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1];
		assign right_e = (i == QUEUE_DEPTH-1) ? new_entry
			: cell_entry[(i == QUEUE_DEPTH-1) ? i : i+1];

		poq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.policy      (policy),
			.live        (live),
			.prev_found  (chain[i]),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.target_id   (target_id),
			.entry       (cell_entry[i]),
			.here        (cell_here[i]),
			.found_out   (chain[i+1])
		);
	end

	assign found = chain[QUEUE_DEPTH];

	// at most one cell flags here, so an OR picks its entry
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cell_here[i])
				sel_entry = sel_entry | cell_entry[i];
		end
	end

endmodule

// ===== rtl/policy_ordered_ready_queue_unit.sv =====
// Usage:
// Requests enter on req (req_valid / req_stall) and results leave on rsp
// (rsp_valid / rsp_stall); an item moves on a clock edge with valid high
// and stall low. Every request gives exactly one result item.
// Each request passes through two states: IDLE takes the item in, and in
// the work cycle in BUSY the row of cells for the addressed queue compares
// all slots against it and shifts at once. A new request is taken only in
// IDLE, not while one is in BUSY; the result shows on rsp the cycle after
// the work cycle. The output register holds a result while the receiver
// stalls, and the next request still enters; its work cycle waits until the output register is free.
// Configuration goes through cfg_we / cfg_index / cfg_wdata, one register
// per write, and is meant to change only while no request is in flight.
// Reset clears both queue counts, sets the next id to one and loads the
// register defaults (policy fcfs, length 10, limit 4). Slot contents are
// not cleared; only slots below a queue's count are ever read.
// ----------------------------------------------------------------------------
// policy_ordered_ready_queue_unit
// Two bounded ready queues kept in policy order with push, pop and remove.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module policy_ordered_ready_queue_unit
	import poq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_wdata,
	input  logic       req_valid,
	output logic       req_stall,
	input  poq_req_t   req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output poq_rsp_t   rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic [2:0] policy_q;
	logic [9:0] canal_len_q;
	logic [3:0] qlimit_q;

	// control
	poq_fsm_t      state_q, state_d;
	logic [CW-1:0] cnt_q [2];
	logic [15:0]   next_id_q;
	logic          rsp_valid_q;
	poq_rsp_t      rsp_q;

	// request held for the work cycle
	poq_req_t   req_s1;
	logic [9:0] quot_s1;

	logic          accept, fire;
	logic [CW-1:0] n, lim, cnt_new;
	logic          full;
	logic [19:0]   burst_def, burst_eff;
	logic [9:0]    prio_eff;
	logic [21:0]   dl_eff;
	poq_entry_t    new_entry;
	poq_cell_ctl_t row_ctl [2];
	logic          row_found [2];
	poq_entry_t    row_sel [2];
	poq_entry_t    hit_entry;
	logic          success;
	logic          found_sel;
	poq_rsp_t      rsp_d;
	logic [CW+2:0] occ_ext;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POLICY_RST;
			canal_len_q <= CANAL_LEN_RST;
			qlimit_q    <= QLIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY:    policy_q    <= cfg_wdata[2:0];
				REG_CANAL_LEN: canal_len_q <= cfg_wdata;
				REG_QLIMIT:    qlimit_q    <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer: take an item in IDLE, work it in BUSY once the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		fire      = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					state_d = FSM_BUSY;
			end
			FSM_BUSY: begin
				if (!rsp_valid_q || !rsp_stall) begin
					fire    = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign accept = req_valid && !req_stall;

	// Capture the request and start the default burst: ceil(length / speed)
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			quot_s1 <= ceil_div_speed(canal_len_q, req.ship_type);
		end
	end

	// Effective fields of a new entry
	always_comb begin
		burst_def = 20'(quot_s1) * 20'(TICK_MS);
		prio_eff  = (req_s1.priority_req != '0) ? req_s1.priority_req
			: type_priority(req_s1.ship_type);
		burst_eff = (req_s1.burst_req != '0) ? req_s1.burst_req : burst_def;
		if (req_s1.deadline_req != '0)
			dl_eff = req_s1.deadline_req;
		else if (req_s1.ship_type == TYPE_PATROL)
			dl_eff = 22'(burst_eff);
		else
			dl_eff = {burst_eff, 2'b00};  // burst*4 of a 20-bit burst always fits
	end

	assign new_entry = '{id: next_id_q, prio: prio_eff, burst: burst_eff, dl: dl_eff};

	// Fullness against the limit; out-of-range limits mean the full depth
	assign n    = cnt_q[req_s1.dir];
	assign lim  = (qlimit_q == '0 || int'(qlimit_q) > QUEUE_DEPTH)
		? CW'(QUEUE_DEPTH) : CW'(qlimit_q);
	assign full = n >= lim;

	// Two rows of cells, one per direction
	for (genvar d = 0; d < 2; d++) begin : g_row
		always_comb begin
			row_ctl[d].mode_ins = req_s1.op == OP_PUSH;
			row_ctl[d].mode_pop = req_s1.op == OP_POP;
			row_ctl[d].wr       = fire && success && (req_s1.dir == 1'(d))
				&& (req_s1.op inside {OP_PUSH, OP_POP, OP_REMOVE});
		end

		poq_row #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_row (
			.clk       (clk),
			.ctl       (row_ctl[d]),
			.policy    (policy_q),
			.cnt       (cnt_q[d]),
			.new_entry (new_entry),
			.target_id (req_s1.target_id),
			.found     (row_found[d]),
			.sel_entry (row_sel[d])
		);
	end

	assign hit_entry = row_sel[req_s1.dir];
	assign found_sel = row_found[req_s1.dir];

	// Result and new count of the addressed queue
	always_comb begin
		rsp_d   = '0;
		success = 1'b0;
		cnt_new = n;
		case (req_s1.op)
			OP_PUSH: begin
				if (full) begin
					rsp_d.status = STAT_FULL;
				end else begin
					success            = 1'b1;
					cnt_new            = n + CW'(1);
					rsp_d.status       = STAT_OK;
					rsp_d.entry_id_out = next_id_q;
					rsp_d.priority_out = prio_eff;
					rsp_d.burst_out    = burst_eff;
					rsp_d.deadline_out = dl_eff;
				end
			end
			OP_POP, OP_REMOVE: begin
				if (!found_sel) begin
					rsp_d.status = (req_s1.op == OP_POP) ? STAT_EMPTY : STAT_NOTFOUND;
				end else begin
					success            = 1'b1;
					cnt_new            = n - CW'(1);
					rsp_d.status       = STAT_OK;
					rsp_d.entry_id_out = hit_entry.id;
					rsp_d.priority_out = hit_entry.prio;
					rsp_d.burst_out    = hit_entry.burst;
					rsp_d.deadline_out = hit_entry.dl;
				end
			end
			default: rsp_d.status = STAT_OK;  // unused op: report only
		endcase
		occ_ext         = {3'b000, cnt_new};
		rsp_d.occupancy = occ_ext[2:0];
	end

	// Queue counts and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0]  <= '0;
			cnt_q[1]  <= '0;
			next_id_q <= NEXT_ID_RST;
		end else if (fire && success) begin
			cnt_q[req_s1.dir] <= cnt_new;
			if (req_s1.op == OP_PUSH)
				next_id_q <= next_id_q + 16'd1;
		end
	end

	// Output register: hold while stalled, load on the work cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (fire)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`POQ_ASSERT_ALWAYS(a_cnt_bound,
		int'(cnt_q[0]) <= QUEUE_DEPTH && int'(cnt_q[1]) <= QUEUE_DEPTH,
		"queue count above depth")
	`POQ_ASSERT_NEXT(a_id_advance, fire && success && req_s1.op == OP_PUSH,
		next_id_q == 16'($past(next_id_q) + 16'd1), "next id did not advance on push")
	`POQ_ASSERT_NEXT(a_other_queue, fire,
		cnt_q[!$past(req_s1.dir)] == $past(cnt_q[!req_s1.dir]),
		"count of the other queue changed")
	`POQ_ASSERT_NEXT(a_fire_result, fire, rsp_valid_q, "work cycle gave no result")

endmodule
